// ===== hdl/pstd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point set total distance: shared package
// Sizes, codes and the command and status records between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package pstd_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_WIDTH = 16;

  localparam int KIND_W      = 2;
  localparam int POS_W       = 6;
  localparam int TOTAL_W     = 29;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int PT_W   = 2 * COORD_WIDTH;
  localparam int SQ_W   = 2 * COORD_WIDTH + 1;
  localparam int ROOT_W = COORD_WIDTH + 1;
  localparam int RT_W   = 2 * ROOT_W + 1;
  localparam int ACC_W  = ROOT_W + 2 * IDX_W;
  localparam int SAT_W  = (ACC_W + 1 > TOTAL_W) ? ACC_W + 1 : TOTAL_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TOTAL  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Purpose of a memory read, carried along with the read data.
  typedef enum logic [1:0] {
    RD_A    = 2'd0,
    RD_B    = 2'd1,
    RD_MOVE = 2'd2
  } rd_kind_e;

  typedef enum logic [1:0] {
    TOT_HOLD = 2'd0,
    TOT_ZERO = 2'd1,
    TOT_SAT  = 2'd2
  } tot_op_e;

  typedef struct packed {
    logic             app_we;
    logic [IDX_W-1:0] app_addr;
    logic             rd_en;
    rd_kind_e         rd_kind;
    logic [IDX_W-1:0] rd_addr;
    logic             acc_clr;
    tot_op_e          tot_op;
  } cmd_t;

  typedef struct packed {
    logic pipe_idle;
  } dp_status_t;

endpackage

// ===== hdl/pstd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pstd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pstd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined floor square root
// One result bit per stage, one radicand accepted every cycle.
// ----------------------------------------------------------------------------
module pstd_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [pstd_pkg::SQ_W-1:0] rad_i,
  output logic                      valid_o,
  output logic [pstd_pkg::ROOT_W-1:0] root_o,
  output logic                      idle_o
);
  import pstd_pkg::*;

  logic              v_q    [ROOT_W];
  logic [RT_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // The remainder holds radicand minus root squared; each stage tries to set
  // one more root bit, from the top down.
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic              v_in;
    logic [RT_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RT_W-1:0]   trial;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = RT_W'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = (RT_W'(root_in) << (K + 1)) + (RT_W'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[s]  <= rem_in - trial;
        root_q[s] <= root_in | (ROOT_W'(1) << K);
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in;
      end
    end
  end

  always_comb begin
    idle_o = 1'b1;
    for (int s = 0; s < ROOT_W; s++) begin
      if (v_q[s]) begin
        idle_o = 1'b0;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

// ===== hdl/pstd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point set total distance: datapath
// Point memory, list moves, pair distance pipeline and the running total.
// ----------------------------------------------------------------------------
module pstd_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pstd_pkg::cmd_t                          cmd_i,
  input  logic signed [pstd_pkg::COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [pstd_pkg::COORD_WIDTH-1:0] y_coord_i,
  output pstd_pkg::dp_status_t                    status_o,
  output logic [pstd_pkg::TOTAL_W-1:0]            total_o
);
  import pstd_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [PT_W-1:0]  wdata;
  logic [PT_W-1:0]  rdata;

  logic             rd_valid_q;
  rd_kind_e         rd_kind_q;
  logic [IDX_W-1:0] rd_addr_q;

  logic [CW-1:0] a_x_q, a_y_q;
  logic [CW-1:0] b_x, b_y;
  logic [CW:0]   dx, dy;

  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [CW-1:0]     abs_x_q, abs_y_q;
  logic [2*CW-1:0]   sq_x_q, sq_y_q;
  logic [SQ_W-1:0]   rad_q;

  logic              root_v;
  logic [ROOT_W-1:0] root;
  logic              sqrt_idle;

  logic [ACC_W-1:0]   acc_q;
  logic [SAT_W-1:0]   doubled;
  logic [TOTAL_W-1:0] total_q;

  // A removal moves each read entry down by one place in the following cycle.
  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.app_addr;
    wdata = {x_coord_i, y_coord_i};
    if (cmd_i.app_we) begin
      we = 1'b1;
    end else if (rd_valid_q && rd_kind_q == RD_MOVE) begin
      we    = 1'b1;
      waddr = rd_addr_q - IDX_W'(1);
      wdata = rdata;
    end
  end

  pstd_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_kind_q  <= RD_A;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      rd_kind_q  <= cmd_i.rd_kind;
      s1_v_q     <= rd_valid_q && rd_kind_q == RD_B;
      s2_v_q     <= s1_v_q;
      s3_v_q     <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= cmd_i.rd_addr;
    if (rd_valid_q && rd_kind_q == RD_A) begin
      a_x_q <= rdata[PT_W-1:CW];
      a_y_q <= rdata[CW-1:0];
    end
  end

  assign b_x = rdata[PT_W-1:CW];
  assign b_y = rdata[CW-1:0];
  assign dx  = {b_x[CW-1], b_x} - {a_x_q[CW-1], a_x_q};
  assign dy  = {b_y[CW-1], b_y} - {a_y_q[CW-1], a_y_q};

  // The difference of two coordinates is at most 2^CW - 1 in magnitude.
  always_ff @(posedge clk_i) begin
    abs_x_q <= dx[CW] ? CW'(~dx + (CW+1)'(1)) : CW'(dx);
    abs_y_q <= dy[CW] ? CW'(~dy + (CW+1)'(1)) : CW'(dy);
    sq_x_q  <= (2*CW)'(abs_x_q) * (2*CW)'(abs_x_q);
    sq_y_q  <= (2*CW)'(abs_y_q) * (2*CW)'(abs_y_q);
    rad_q   <= SQ_W'(sq_x_q) + SQ_W'(sq_y_q);
  end

  pstd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_v_q),
    .rad_i   (rad_q),
    .valid_o (root_v),
    .root_o  (root),
    .idle_o  (sqrt_idle)
  );

  // Only pairs with i < j are visited; doubling gives the ordered-pair sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (root_v) begin
      acc_q <= acc_q + ACC_W'(root);
    end
  end

  assign doubled = SAT_W'({acc_q, 1'b0});

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.tot_op)
      TOT_ZERO: total_q <= '0;
      TOT_SAT: begin
        if (doubled > SAT_W'(TOTAL_MAX)) begin
          total_q <= TOTAL_MAX;
        end else begin
          total_q <= TOTAL_W'(doubled);
        end
      end
      default: total_q <= total_q;
    endcase
  end

  assign status_o.pipe_idle = !rd_valid_q && !s1_v_q && !s2_v_q && !s3_v_q && sqrt_idle;
  assign total_o = total_q;

endmodule

// ===== hdl/pstd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point set total distance: controller
// Sequences appends, removals and pair sweeps and keeps the point count.
// ----------------------------------------------------------------------------
module pstd_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [pstd_pkg::KIND_W-1:0]        kind_i,
  input  logic [pstd_pkg::POS_W-1:0]         position_i,
  output pstd_pkg::cmd_t                     cmd_o,
  input  pstd_pkg::dp_status_t               status_i,
  output logic                               done_o,
  output logic [pstd_pkg::COUNT_OUT_W-1:0]   point_count_o,
  output logic [pstd_pkg::STATUS_W-1:0]      status_o
);
  import pstd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOVE  = 6'b000010,
    S_FIN   = 6'b000100,
    S_ROW   = 6'b001000,
    S_PAIR  = 6'b010000,
    S_DRAIN = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic             done_q, done_d;
  status_e          stat_q, stat_d;

  kind_e            kind;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] last;

  assign kind    = kind_e'(kind_i);
  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign last    = count_q - CNT_W'(1);
  assign busy    = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    done_d  = 1'b0;
    stat_d  = stat_q;

    cmd_o          = '0;
    cmd_o.app_addr = count_q[IDX_W-1:0];
    cmd_o.rd_kind  = RD_A;
    cmd_o.tot_op   = TOT_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (kind)
            KIND_APPEND: begin
              done_d       = 1'b1;
              cmd_o.tot_op = TOT_ZERO;
              if (count_q == CNT_W'(MAX_POINTS)) begin
                stat_d = STATUS_FULL;
              end else begin
                stat_d       = STATUS_OK;
                cmd_o.app_we = 1'b1;
                count_d      = count_q + CNT_W'(1);
              end
            end
            KIND_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                done_d       = 1'b1;
                stat_d       = STATUS_RANGE;
                cmd_o.tot_op = TOT_ZERO;
              end else if (pos_ext + CMP_W'(1) == cnt_ext) begin
                // Removing the last point needs no entries to move.
                done_d       = 1'b1;
                stat_d       = STATUS_OK;
                cmd_o.tot_op = TOT_ZERO;
                count_d      = last;
              end else begin
                j_d     = pos_ext[IDX_W-1:0] + IDX_W'(1);
                state_d = S_MOVE;
              end
            end
            KIND_TOTAL: begin
              cmd_o.acc_clr = 1'b1;
              i_d           = '0;
              if (count_q < CNT_W'(2)) begin
                state_d = S_DRAIN;
              end else begin
                state_d = S_ROW;
              end
            end
            default: begin
              done_d       = 1'b1;
              stat_d       = STATUS_OK;
              cmd_o.tot_op = TOT_ZERO;
            end
          endcase
        end
      end
      S_MOVE: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_kind = RD_MOVE;
        cmd_o.rd_addr = j_q;
        if (CNT_W'(j_q) == last) begin
          state_d = S_FIN;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_FIN: begin
        // The final move is written at the end of this cycle.
        done_d       = 1'b1;
        stat_d       = STATUS_OK;
        cmd_o.tot_op = TOT_ZERO;
        count_d      = last;
        state_d      = S_IDLE;
      end
      S_ROW: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_kind = RD_A;
        cmd_o.rd_addr = i_q;
        j_d           = i_q + IDX_W'(1);
        state_d       = S_PAIR;
      end
      S_PAIR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_kind = RD_B;
        cmd_o.rd_addr = j_q;
        if (CNT_W'(j_q) == last) begin
          if (CNT_W'(i_q) + CNT_W'(1) == last) begin
            state_d = S_DRAIN;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_ROW;
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (status_i.pipe_idle) begin
          done_d       = 1'b1;
          stat_d       = STATUS_OK;
          cmd_o.tot_op = TOT_SAT;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
      stat_q  <= STATUS_OK;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
      done_q  <= done_d;
      stat_q  <= stat_d;
    end
  end

  assign done_o        = done_q;
  assign point_count_o = COUNT_OUT_W'(count_q);
  assign status_o      = stat_q;

endmodule

// ===== hdl/point_set_total_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point set total distance: top level
// Ordered list of 2-D points with append, remove and total-distance commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result appears
// on total_distance_o, point_count_o and status_o for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must capture the beat in
// that cycle. An append, a rejected command, the removal of the last point or
// the unused kind keeps busy low, and its result beat comes in the next cycle.
// Any other removal keeps busy high while the later entries move down, one
// entry per cycle through the point memory. A total keeps busy high while
// the pairs are swept and the pipeline drains: when there are two or more
// points, each row reads its first point and then every later point, one
// read per cycle from the single memory read port, each pair goes through a
// pipelined square root, and the pipeline then drains.
// For these longer commands the result beat comes in the cycle in which busy
// falls.
module point_set_total_distance (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [pstd_pkg::KIND_W-1:0]             kind_i,
  input  logic signed [pstd_pkg::COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [pstd_pkg::COORD_WIDTH-1:0] y_coord_i,
  input  logic [pstd_pkg::POS_W-1:0]              position_i,
  output logic                                    done_o,
  output logic [pstd_pkg::TOTAL_W-1:0]            total_distance_o,
  output logic [pstd_pkg::COUNT_OUT_W-1:0]        point_count_o,
  output logic [pstd_pkg::STATUS_W-1:0]           status_o
);
  import pstd_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  pstd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .position_i    (position_i),
    .cmd_o         (cmd),
    .status_i      (dp_status),
    .done_o        (done_o),
    .point_count_o (point_count_o),
    .status_o      (status_o)
  );

  pstd_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .status_o  (dp_status),
    .total_o   (total_distance_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point set total distance: testbench
// Drives append, remove, total and unused commands into the point list. It
// starts with a directed table and follows it with random commands in bursts.
// Each result beat is checked against a local copy of the list, or, for
// directed rows that carry results written in by hand, against those.
// ----------------------------------------------------------------------------
module tb_top;
  import pstd_pkg::*;

  typedef struct packed {
    logic [TOTAL_W-1:0]     total;
    logic [COUNT_OUT_W-1:0] count;
    status_e                status;
  } dist_res_t;

  typedef struct packed {
    kind_e                         kind;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [POS_W-1:0]              pos;
    logic [6:0]                    reps;
    logic                          rnd_xy;
    logic                          typed;
    dist_res_t                     want;
  } dir_row_t;

  localparam int NDIR = 25;
  localparam int RANDOM_ITEMS = 36;

  // A row with rnd_xy set takes fresh random coordinates on every repeat.
  // Rows with typed set are checked against the hand-written result.
  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd0, STATUS_RANGE}},
    '{KIND_NONE,   16'sh7fff, 16'sh8000, 6'd63, 7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_APPEND, 16'sh8000, 16'sh8000, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd1, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd1, STATUS_OK}},
    '{KIND_APPEND, 16'sh7fff, 16'sh7fff, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd2, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd185360, 7'd2, STATUS_OK}},
    '{KIND_APPEND, 16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd3, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd1,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd2, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_APPEND, 16'sh7fff, 16'sh8000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_APPEND, 16'sh8000, 16'sh7fff, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_APPEND, 16'sh0000, 16'sh0000, 6'd0,  7'd61, 1'b1, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_APPEND, 16'sh0001, 16'shffff, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd64, STATUS_FULL}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd63, 7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd63, STATUS_OK}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd63, 7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd63, STATUS_RANGE}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_NONE,   16'sh8000, 16'sh7fff, 6'd0,  7'd1,  1'b0, 1'b1,
      '{29'd0, 7'd62, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_REMOVE, 16'sh0000, 16'sh0000, 6'd5,  7'd20, 1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}},
    '{KIND_TOTAL,  16'sh0000, 16'sh0000, 6'd0,  7'd1,  1'b0, 1'b0,
      '{29'd0, 7'd0, STATUS_OK}}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [KIND_W-1:0]             kind_d = KIND_NONE;
  logic signed [COORD_WIDTH-1:0] x_d = '0;
  logic signed [COORD_WIDTH-1:0] y_d = '0;
  logic [POS_W-1:0]              pos_d = '0;
  logic                          done_o;
  logic [TOTAL_W-1:0]            total_distance_o;
  logic [COUNT_OUT_W-1:0]        point_count_o;
  logic [STATUS_W-1:0]           status_o;

  // Hand-written result travelling with the beat that is on the inputs.
  logic      beat_typed = 1'b0;
  dist_res_t beat_want = '0;

  logic signed [COORD_WIDTH-1:0] pts_x [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] pts_y [MAX_POINTS];
  int                            pts_n = 0;

  dist_res_t pending_results [$];
  int        mismatches = 0;
  int        burst_left = 0;

  point_set_total_distance dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_d),
    .x_coord_i        (x_d),
    .y_coord_i        (y_d),
    .position_i       (pos_d),
    .done_o           (done_o),
    .total_distance_o (total_distance_o),
    .point_count_o    (point_count_o),
    .status_o         (status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Updates the local list for one accepted command and returns its result.
  function automatic dist_res_t apply_command(kind_e k, logic signed [COORD_WIDTH-1:0] x,
                                              logic signed [COORD_WIDTH-1:0] y,
                                              logic [POS_W-1:0] p);
    dist_res_t       res;
    longint unsigned sum;
    longint          dx;
    longint          dy;
    res = '{'0, '0, STATUS_OK};
    sum = 0;
    case (k)
      KIND_APPEND: begin
        if (pts_n >= MAX_POINTS) begin
          res.status = STATUS_FULL;
        end else begin
          pts_x[pts_n] = x;
          pts_y[pts_n] = y;
          pts_n++;
        end
      end
      KIND_REMOVE: begin
        if (int'(p) >= pts_n) begin
          res.status = STATUS_RANGE;
        end else begin
          for (int i = int'(p); i < pts_n - 1; i++) begin
            pts_x[i] = pts_x[i + 1];
            pts_y[i] = pts_y[i + 1];
          end
          pts_n--;
        end
      end
      KIND_TOTAL: begin
        for (int i = 0; i < pts_n; i++) begin
          for (int j = 0; j < pts_n; j++) begin
            dx = longint'(pts_x[j]) - longint'(pts_x[i]);
            dy = longint'(pts_y[j]) - longint'(pts_y[i]);
            sum += floor_root(longint'(dx * dx + dy * dy));
          end
        end
        res.total = (sum > longint'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
      default: ;
    endcase
    res.count = pts_n[COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic void note_mismatch(string what, dist_res_t want, dist_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: %s: expected total %0d count %0d status %0d, ",
                "got total %0d count %0d status %0d"},
               $time, what, want.total, want.count, want.status,
               got.total, got.count, got.status);
  endfunction

  // Acceptance and result capture, both sampled at the rising edge.
  always @(posedge clk_i) begin
    dist_res_t got;
    dist_res_t want;
    dist_res_t pred;
    if (rst_ni) begin
      if (start && !busy) begin
        pred = apply_command(kind_e'(kind_d), x_d, y_d, pos_d);
        pending_results = {pending_results, (beat_typed ? beat_want : pred)};
      end
      if (done_o) begin
        got = '{total_distance_o, point_count_o, status_e'(status_o)};
        if (pending_results.size() == 0) begin
          note_mismatch("result beat with nothing pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.total !== want.total || got.count !== want.count ||
              got.status !== want.status)
            note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return COORD_WIDTH'($urandom_range(0, 64) - 32);
      default: return COORD_WIDTH'($urandom());
    endcase
  endfunction

  function automatic int next_len(int len, kind_e k, logic [POS_W-1:0] p);
    if (k == KIND_APPEND && len < MAX_POINTS) return len + 1;
    if (k == KIND_REMOVE && int'(p) < len) return len - 1;
    return len;
  endfunction

  // The sender works in bursts; between bursts it may lower start for a random gap.
  task automatic issue_beat(kind_e k, logic signed [COORD_WIDTH-1:0] x,
                            logic signed [COORD_WIDTH-1:0] y, logic [POS_W-1:0] p,
                            logic typed, dist_res_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    start      <= 1'b1;
    kind_d     <= k;
    x_d        <= x;
    y_d        <= y;
    pos_d      <= p;
    beat_typed <= typed;
    beat_want  <= w;
    do @(posedge clk_i); while (busy);
    burst_left--;
  endtask

  initial begin
    int                            list_len;
    int                            pick;
    kind_e                         k;
    logic signed [COORD_WIDTH-1:0] xv;
    logic signed [COORD_WIDTH-1:0] yv;
    logic [POS_W-1:0]              pv;
    list_len = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NDIR; r++) begin
      for (int n = 0; n < int'(DIR_TAB[r].reps); n++) begin
        xv = DIR_TAB[r].rnd_xy ? rand_coord() : DIR_TAB[r].x;
        yv = DIR_TAB[r].rnd_xy ? rand_coord() : DIR_TAB[r].y;
        issue_beat(DIR_TAB[r].kind, xv, yv, DIR_TAB[r].pos, DIR_TAB[r].typed,
                   DIR_TAB[r].want);
        list_len = next_len(list_len, DIR_TAB[r].kind, DIR_TAB[r].pos);
      end
    end

    // Random commands; removals are favoured once the list grows, so that
    // totals stay short.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) k = KIND_NONE;
      else if (pick < 42) k = KIND_APPEND;
      else if (pick < 67) k = KIND_REMOVE;
      else k = KIND_TOTAL;
      if (k == KIND_APPEND && list_len >= 16 && $urandom_range(0, 3) != 0)
        k = KIND_REMOVE;
      if (list_len > 0 && $urandom_range(0, 4) != 0)
        pv = POS_W'($urandom_range(0, list_len - 1));
      else
        pv = POS_W'($urandom_range(0, 63));
      xv = rand_coord();
      yv = rand_coord();
      issue_beat(k, xv, yv, pv, 1'b0, '0);
      list_len = next_len(list_len, k, pv);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
